// File: sv/spm4d_pkg.sv
// Package for the 4D sphere point generator: state codes, field widths and constants.
// Used by sphere_point_4d_marsaglia_top and its checker; depends on nothing.
package spm4d_pkg;

   localparam int SAMPLE_BITS_DEFAULT = 16;
   localparam int RADIUS_W            = 16;
   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 16'd4096;
   localparam int COORD_W             = 22;
   localparam int COORD_COUNT         = 4;
   localparam int RSP_DATA_W          = 88;

   // 1.0 in Q2.32, 1.0 in Q1.16, largest output magnitude in Q6.16
   localparam logic [33:0] ONE_Q32 = 34'h1_0000_0000;
   localparam logic [16:0] ONE_Q16 = 17'h1_0000;
   localparam logic [COORD_W-1:0] OUT_MAX = 22'd1048576;

   localparam int MUL_STEPS  = 33;
   localparam int DIV_STEPS  = 33;
   localparam int SQRT_STEPS = 17;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ_A,
      ST_SQ_B,
      ST_CHECK,
      ST_MUL,
      ST_DIV,
      ST_SQRT,
      ST_EMIT,
      ST_DONE
   } state_type;

endpackage

// File: sv/sphere_point_4d_marsaglia_top.sv
// Channel   | Dir | Fields (low bit first)
// req_      | in  | tdata: uniform_a, uniform_b
// rsp_      | out | tdata: coord_0, coord_1, coord_2, coord_3
// csr_      | in  | wdata: radius
// After a first pair the block runs two squares and one check before it is ready again.
// An accepted second pair runs, for each of the last two coordinates, a bit-serial
// multiply, restoring divide and square root; then the four coordinates pass one by one
// through the shared radius multiplier. The radius multiply with rounding and saturation
// sets the clock.
// Reset is synchronous: phase returns to 0, radius to 1.0, no result pending.
// A finished result waits in the output register; new pairs are taken meanwhile.
// Depends on spm4d_pkg.
module sphere_point_4d_marsaglia_top #(
   parameter int SAMPLE_BITS = spm4d_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // uniform_a, uniform_b
   input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // coord_0, coord_1, coord_2, coord_3
   output logic [spm4d_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic csr_wen,
   input  logic [spm4d_pkg::RADIUS_W-1:0] csr_wdata
);
   import spm4d_pkg::*;

   state_type state_ff, state_in;

   logic [RADIUS_W-1:0] radius_ff;
   logic                phase_ff;
   logic [5:0]          cnt_ff;

   logic        cur_neg_a_ff, cur_neg_b_ff;
   logic [16:0] cur_mag_a_ff, cur_mag_b_ff;
   logic [33:0] sq_a_ff, sq_b_ff;
   logic [33:0] norm_ff;

   logic        held_neg_a_ff, held_neg_b_ff;
   logic [16:0] held_mag_a_ff, held_mag_b_ff;
   logic [32:0] rest_ff;

   logic        sel_ff;
   logic [66:0] acc_ff;
   logic [33:0] sq_op_ff, sq_res_ff, sq_bit_ff;
   logic [16:0] root_a_ff, root_b_ff;

   logic [COORD_W-1:0] coord_ff [COORD_COUNT];
   logic               rsp_tvalid_ff;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff;

   // sample alignment to Q0.16 and y = 1 - 2u as sign and magnitude
   logic [SAMPLE_BITS+15:0] ext_a, ext_b;
   logic [15:0] u_a, u_b;
   logic [16:0] two_u_a, two_u_b;
   logic        neg_a, neg_b;
   logic [16:0] mag_a, mag_b;

   assign ext_a   = {req_tdata[SAMPLE_BITS-1:0], 16'd0};
   assign ext_b   = {req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS], 16'd0};
   assign u_a     = ext_a[SAMPLE_BITS+15 -: 16];
   assign u_b     = ext_b[SAMPLE_BITS+15 -: 16];
   assign two_u_a = {u_a, 1'b0};
   assign two_u_b = {u_b, 1'b0};
   assign neg_a   = two_u_a > ONE_Q16;
   assign neg_b   = two_u_b > ONE_Q16;
   assign mag_a   = neg_a ? two_u_a - ONE_Q16 : ONE_Q16 - two_u_a;
   assign mag_b   = neg_b ? two_u_b - ONE_Q16 : ONE_Q16 - two_u_b;

   logic [33:0] square;
   assign square = 34'(state_ff == ST_SQ_A ? cur_mag_a_ff : cur_mag_b_ff)
                 * 34'(state_ff == ST_SQ_A ? cur_mag_a_ff : cur_mag_b_ff);

   logic [33:0] norm_sum;
   logic        norm_ok, norm_in_disc;
   assign norm_sum     = sq_a_ff + sq_b_ff;
   assign norm_in_disc = norm_sum <= ONE_Q32;
   assign norm_ok      = norm_in_disc && (norm_sum != 34'd0);

   // serial multiply step: add multiplicand on low bit, shift right
   logic [33:0] mcand;
   logic [34:0] mul_sum;
   assign mcand   = sel_ff ? sq_b_ff : sq_a_ff;
   assign mul_sum = 35'(acc_ff[66:33]) + (acc_ff[0] ? 35'(mcand) : 35'd0);

   // restoring divide step
   logic [34:0] div_t, div_r;
   logic        div_ge;
   assign div_t  = {acc_ff[66:33], acc_ff[32]};
   assign div_ge = div_t >= 35'(norm_ff);
   assign div_r  = div_ge ? div_t - 35'(norm_ff) : div_t;

   // square root step
   logic [33:0] sq_trial;
   logic        sq_ge;
   assign sq_trial = sq_res_ff + sq_bit_ff;
   assign sq_ge    = sq_op_ff >= sq_trial;

   // shared radius multiplier with rounding and saturation
   logic [16:0]        emit_mag;
   logic               emit_neg;
   logic [32:0]        emit_prod;
   logic [33:0]        emit_rnd;
   logic [COORD_W-1:0] emit_q, emit_sat, emit_val;
   always_comb begin
      unique case (cnt_ff[1:0])
         2'd0: begin emit_mag = held_mag_a_ff; emit_neg = held_neg_a_ff; end
         2'd1: begin emit_mag = held_mag_b_ff; emit_neg = held_neg_b_ff; end
         2'd2: begin emit_mag = root_a_ff;     emit_neg = cur_neg_a_ff;  end
         default: begin emit_mag = root_b_ff;  emit_neg = cur_neg_b_ff;  end
      endcase
   end
   assign emit_prod = 33'(radius_ff) * 33'(emit_mag);
   assign emit_rnd  = 34'(emit_prod) + 34'd2048;
   assign emit_q    = emit_rnd[33:12];
   assign emit_sat  = emit_q > OUT_MAX ? OUT_MAX : emit_q;
   assign emit_val  = emit_neg ? COORD_W'(-emit_sat) : emit_sat;

   logic out_free;
   assign out_free = !rsp_tvalid_ff || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_tvalid) state_in = ST_SQ_A;
         ST_SQ_A:  state_in = ST_SQ_B;
         ST_SQ_B:  state_in = ST_CHECK;
         ST_CHECK: state_in = (phase_ff && norm_ok) ? ST_MUL : ST_IDLE;
         ST_MUL:   if (cnt_ff == 6'(MUL_STEPS-1)) state_in = ST_DIV;
         ST_DIV:   if (cnt_ff == 6'(DIV_STEPS-1)) state_in = ST_SQRT;
         ST_SQRT:  if (cnt_ff == 6'(SQRT_STEPS-1)) state_in = sel_ff ? ST_EMIT : ST_MUL;
         ST_EMIT:  if (cnt_ff == 6'(COORD_COUNT-1)) state_in = ST_DONE;
         ST_DONE:  if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      rsp_tvalid = rsp_tvalid_ff;
      rsp_tdata  = rsp_tdata_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         radius_ff     <= RADIUS_RESET;
         phase_ff      <= 1'b0;
         cnt_ff        <= '0;
         sel_ff        <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wen) radius_ff <= csr_wdata;
         if (state_in != state_ff) begin
            cnt_ff <= '0;
         end else begin
            cnt_ff <= cnt_ff + 6'd1;
         end
         if (state_ff == ST_CHECK) begin
            sel_ff <= 1'b0;
            if (!phase_ff && norm_in_disc) phase_ff <= 1'b1;
            if (phase_ff && norm_ok) phase_ff <= 1'b0;
         end
         if (state_ff == ST_SQRT && cnt_ff == 6'(SQRT_STEPS-1)) sel_ff <= 1'b1;
         if (state_ff == ST_DONE && out_free) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   // datapath, no reset needed
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            cur_neg_a_ff <= neg_a;
            cur_neg_b_ff <= neg_b;
            cur_mag_a_ff <= mag_a;
            cur_mag_b_ff <= mag_b;
         end
         ST_SQ_A: sq_a_ff <= square;
         ST_SQ_B: sq_b_ff <= square;
         ST_CHECK: begin
            norm_ff <= norm_sum;
            acc_ff  <= {34'd0, rest_ff};
            if (!phase_ff && norm_in_disc) begin
               held_neg_a_ff <= cur_neg_a_ff;
               held_neg_b_ff <= cur_neg_b_ff;
               held_mag_a_ff <= cur_mag_a_ff;
               held_mag_b_ff <= cur_mag_b_ff;
               rest_ff       <= 33'(ONE_Q32 - norm_sum);
            end
         end
         ST_MUL: acc_ff <= {mul_sum, acc_ff[32:1]};
         ST_DIV: begin
            acc_ff <= {div_r[33:0], acc_ff[31:0], div_ge};
            if (cnt_ff == 6'(DIV_STEPS-1)) begin
               sq_op_ff  <= {acc_ff[31:0], div_ge} == 33'd0 ? 34'd0
                          : {1'b0, acc_ff[31:0], div_ge};
               sq_res_ff <= '0;
               sq_bit_ff <= ONE_Q32;
            end
         end
         ST_SQRT: begin
            if (sq_ge) begin
               sq_op_ff  <= sq_op_ff - sq_trial;
               sq_res_ff <= (sq_res_ff >> 1) + sq_bit_ff;
            end else begin
               sq_res_ff <= sq_res_ff >> 1;
            end
            sq_bit_ff <= sq_bit_ff >> 2;
            if (cnt_ff == 6'(SQRT_STEPS-1)) begin
               // reload the multiply for the second coordinate
               acc_ff <= {34'd0, rest_ff};
               if (sel_ff) begin
                  root_b_ff <= sq_ge ? 17'((sq_res_ff >> 1) + sq_bit_ff)
                                     : 17'(sq_res_ff >> 1);
               end else begin
                  root_a_ff <= sq_ge ? 17'((sq_res_ff >> 1) + sq_bit_ff)
                                     : 17'(sq_res_ff >> 1);
               end
            end
         end
         ST_EMIT: coord_ff[cnt_ff[1:0]] <= emit_val;
         ST_DONE: begin
            if (out_free) begin
               rsp_tdata_ff <= {coord_ff[3], coord_ff[2], coord_ff[1], coord_ff[0]};
            end
         end
         default: ;
      endcase
   end

endmodule

// File: sv/spm4d_checker.sv
// Port-level checks for sphere_point_4d_marsaglia_top, bound to every instance.
// Depends on spm4d_pkg.
module spm4d_checker #(
   parameter int SAMPLE_BITS = spm4d_pkg::SAMPLE_BITS_DEFAULT
) (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [spm4d_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import spm4d_pkg::*;

   // result held until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped before transfer");

   // nothing pending right after reset
   assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("result present after reset");

   // a result does not become valid directly after an input transfer
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tvalid && req_tready))
      else $error("result too soon after input transfer");

   // saturated range on the first coordinate
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[COORD_W-1:0]) <= $signed(OUT_MAX))
         && ($signed(rsp_tdata[COORD_W-1:0]) >= -$signed(OUT_MAX)))
      else $error("coordinate out of range");

endmodule

bind sphere_point_4d_marsaglia_top spm4d_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);

// File: tb/sv/tb_sphere_point_4d_marsaglia_top.sv
// Self-checking bench for the 4D Marsaglia sphere point generator: directed and random
// sample pairs, random stalls on both streams, radius changes between phases.
// Depends on spm4d_pkg and sphere_point_4d_marsaglia_top.
module tb_sphere_point_4d_marsaglia_top;
   timeunit 1ns;
   timeprecision 1ps;
   import spm4d_pkg::*;

   typedef struct packed {
      logic [COORD_W-1:0] c3;
      logic [COORD_W-1:0] c2;
      logic [COORD_W-1:0] c1;
      logic [COORD_W-1:0] c0;
   } point_type;

   class point_scoreboard_type;
      bit [15:0] radius;
      bit        phase;
      longint    hy1, hy2;
      longint unsigned hnorm;
      point_type pending_pts[$];
      int        errors;

      function new();
         radius = RADIUS_RESET;
         phase = 0;
         hy1 = 0;
         hy2 = 0;
         hnorm = 0;
         errors = 0;
      endfunction

      function longint sample_to_y(bit [15:0] u);
         return 65536 - 2 * longint'(u);
      endfunction

      function longint unsigned abs_val(longint v);
         return v < 0 ? -v : v;
      endfunction

      function longint unsigned int_sqrt(longint unsigned op);
         longint unsigned res, bt;
         res = 0;
         bt = 64'd1 << 34;
         while (bt > op) bt >>= 2;
         while (bt != 0) begin
            if (op >= res + bt) begin
               op -= res + bt;
               res = (res >> 1) + bt;
            end else begin
               res >>= 1;
            end
            bt >>= 2;
         end
         return res;
      endfunction

      // floor(h*g/d) without overflowing 64 bits
      function longint unsigned ratio(longint unsigned h, longint unsigned g,
                                      longint unsigned d);
         longint unsigned a, qa, ra, rest;
         a = h * (g >> 16);
         qa = a / d;
         ra = a % d;
         rest = (ra << 16) + h * (g & 64'hFFFF);
         return (qa << 16) + rest / d;
      endfunction

      function logic [COORD_W-1:0] scale_coord(bit neg, longint unsigned m16);
         longint unsigned m;
         longint v;
         m = (longint'(radius) * m16 + 2048) >> 12;
         if (m > OUT_MAX) m = OUT_MAX;
         v = neg ? -longint'(m) : longint'(m);
         return v[COORD_W-1:0];
      endfunction

      function void note_pair(bit [15:0] ua, bit [15:0] ub);
         longint ya, yb;
         longint unsigned ma, mb, norm, rest;
         point_type p;
         ya = sample_to_y(ua);
         yb = sample_to_y(ub);
         ma = abs_val(ya);
         mb = abs_val(yb);
         norm = ma * ma + mb * mb;
         if (!phase) begin
            if (norm <= 64'h1_0000_0000) begin
               hy1 = ya;
               hy2 = yb;
               hnorm = norm;
               phase = 1;
            end
         end else if (norm != 0 && norm <= 64'h1_0000_0000) begin
            rest = 64'h1_0000_0000 - hnorm;
            p.c0 = scale_coord(hy1 < 0, abs_val(hy1));
            p.c1 = scale_coord(hy2 < 0, abs_val(hy2));
            p.c2 = scale_coord(ya < 0, int_sqrt(ratio(ma * ma, rest, norm)));
            p.c3 = scale_coord(yb < 0, int_sqrt(ratio(mb * mb, rest, norm)));
            pending_pts.push_back(p);
            phase = 0;
         end
      endfunction

      function void check_point(point_type got);
         point_type want;
         if (pending_pts.size() == 0) begin
            $display("%0t: unexpected point %h", $realtime, got);
            errors++;
            return;
         end
         want = pending_pts.pop_front();
         if (got.c0 !== want.c0) begin
            $display("%0t: coord_0 expected %h actual %h", $realtime, want.c0, got.c0);
            errors++;
         end
         if (got.c1 !== want.c1) begin
            $display("%0t: coord_1 expected %h actual %h", $realtime, want.c1, got.c1);
            errors++;
         end
         if (got.c2 !== want.c2) begin
            $display("%0t: coord_2 expected %h actual %h", $realtime, want.c2, got.c2);
            errors++;
         end
         if (got.c3 !== want.c3) begin
            $display("%0t: coord_3 expected %h actual %h", $realtime, want.c3, got.c3);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic        csr_wen = 0;
   logic [15:0] csr_wdata = '0;

   point_scoreboard_type sb = new();
   bit no_idle = 0;

   sphere_point_4d_marsaglia_top dut (.*);

   initial forever #5 clock = ~clock;

   initial begin
      #50_000_000;
      $display("FAIL sphere_point_4d_marsaglia_top");
      $finish;
   end

   // Sink side: random stall, check each transfer.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_point(point_type'(rsp_tdata));
   end
   always @(negedge clock) rsp_tready <= no_idle || ($urandom_range(99) >= 25);

   // Leaves tvalid high after the transfer; the next call or the caller drops it.
   task automatic send_pair(bit [15:0] ua, bit [15:0] ub);
      while (!no_idle && $urandom_range(99) < 25) begin
         req_tvalid <= 0;
         @(negedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {ub, ua};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_pair(ua, ub);
      @(negedge clock);
   endtask

   // Sample whose y lies inside the unit disk when paired with a similar one.
   function automatic bit [15:0] inner_sample();
      return 16'(32768 + $signed($urandom_range(46000)) - 23000);
   endfunction

   task automatic write_radius(bit [15:0] r);
      while (sb.pending_pts.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      csr_wen <= 1;
      csr_wdata <= r;
      @(negedge clock);
      csr_wen <= 0;
      sb.radius = r;
   endtask

   initial begin
      bit [15:0] radii[6];
      int n;
      radii = '{16'd4096, 16'd65535, 16'd0, 16'd1, 16'd12345, 16'd2048};
      repeat (2) @(negedge clock);
      reset <= 0;
      @(negedge clock);
      // directed: corners, norm exactly one, zero norm, rejections
      send_pair(16'h8000, 16'h8000);
      send_pair(16'h0000, 16'h8000);
      send_pair(16'h8000, 16'h8000);
      send_pair(16'hFFFF, 16'h8000);
      send_pair(16'h0000, 16'h0000);
      send_pair(16'h0000, 16'h8000);
      send_pair(16'h0000, 16'hFFFF);
      send_pair(16'h8000, 16'h0000);
      send_pair(16'hFFFF, 16'hFFFF);
      send_pair(16'h4000, 16'hC000);
      send_pair(16'h1234, 16'hABCD);
      send_pair(16'h5555, 16'hAAAA);
      send_pair(16'h8001, 16'h7FFF);
      send_pair(16'h0001, 16'h8000);
      for (int ph = 0; ph < 6; ph++) begin
         req_tvalid <= 0;
         write_radius(radii[ph]);
         no_idle = (ph == 3);
         n = (ph == 0) ? 300 : 150;
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 80) send_pair(inner_sample(), inner_sample());
            else send_pair(16'($urandom), 16'($urandom));
         end
      end
      req_tvalid <= 0;
      no_idle = 0;
      while (sb.pending_pts.size() != 0) @(negedge clock);
      repeat (400) @(negedge clock);
      if (sb.errors == 0) $display("PASS sphere_point_4d_marsaglia_top");
      else $display("FAIL sphere_point_4d_marsaglia_top");
      $finish;
   end
endmodule
